// ===== rtl/ahfs_pkg.sv =====
package ahfs_pkg;

   localparam int HEADER_BYTES_DEF = 512;
   localparam int MIN_HEADER = 12;

   // Byte 0 of each magic sits in the low bits
   localparam logic [31:0] RIFF_MAGIC = 32'h4646_4952;
   localparam logic [31:0] WAVE_MAGIC = 32'h4556_4157;
   localparam logic [31:0] FMT_MAGIC  = 32'h2074_6D66;
   localparam logic [23:0] ID3_MAGIC  = 24'h33_4449;
   localparam logic [7:0]  SYNC_BYTE  = 8'hFF;
   localparam logic [7:0]  SYNC_MASK  = 8'hE0;

   localparam logic [15:0] TAG_PCM   = 16'h0001;
   localparam logic [15:0] TAG_ALAW  = 16'h0006;
   localparam logic [15:0] TAG_ULAW  = 16'h0007;
   localparam logic [15:0] TAG_ADPCM = 16'h0011;

   typedef enum logic [2:0] {
      CODEC_UNKNOWN = 3'd0,
      CODEC_MP3     = 3'd1,
      CODEC_PCM     = 3'd2,
      CODEC_ALAW    = 3'd3,
      CODEC_ULAW    = 3'd4,
      CODEC_ADPCM   = 3'd5
   } codec_type;

   typedef enum logic [1:0] {
      HINT_OTHER = 2'd0,
      HINT_MP3   = 2'd1,
      HINT_WAV   = 2'd2,
      HINT_SPARE = 2'd3
   } hint_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] data_byte;
      logic       last;
      logic [1:0] ext_hint;
   } step_type;

   function automatic codec_type map_format(input logic [15:0] tag);
      codec_type kind;
      case (tag)
         TAG_PCM:   kind = CODEC_PCM;
         TAG_ALAW:  kind = CODEC_ALAW;
         TAG_ULAW:  kind = CODEC_ULAW;
         TAG_ADPCM: kind = CODEC_ADPCM;
         default:   kind = CODEC_PCM;
      endcase
      return kind;
   endfunction

endpackage

// ===== rtl/ahfs_core.sv =====
module ahfs_core #(
   parameter int HEADER_BYTES = ahfs_pkg::HEADER_BYTES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  ahfs_pkg::step_type  step,
   output ahfs_pkg::codec_type code
);
   import ahfs_pkg::*;

   localparam int CW = $clog2(HEADER_BYTES + 1);
   localparam logic [CW-1:0] HB = CW'(HEADER_BYTES);
   localparam logic [CW-1:0] MINH = CW'(MIN_HEADER);

   logic [CW-1:0] count_ff, count_in;
   logic [2:0]    magic_ff, magic_in;   // bit0 wav, bit1 id3, bit2 sync
   logic [3:0]    phase_ff, phase_in;
   logic          fmt_ff, fmt_in;
   logic [31:0]   len_ff, len_in;
   logic [CW-1:0] skip_ff, skip_in;
   logic [7:0]    fmt_low_ff, fmt_low_in;
   logic          decided_ff, decided_in;
   codec_type     kind_ff, kind_in;

   logic [7:0]  b;
   logic [1:0]  idx;
   logic [31:0] full_len;
   logic [32:0] padded;

   assign b        = step.data_byte;
   assign idx      = count_ff[1:0];
   assign full_len = {b, len_ff[23:0]};
   assign padded   = {1'b0, full_len} + {32'd0, full_len[0]};

   always_comb begin
      count_in   = count_ff;
      magic_in   = magic_ff;
      phase_in   = phase_ff;
      fmt_in     = fmt_ff;
      len_in     = len_ff;
      skip_in    = skip_ff;
      fmt_low_in = fmt_low_ff;
      decided_in = decided_ff;
      kind_in    = kind_ff;
      if (step.valid && count_ff < HB) begin
         if (count_ff < CW'(4) && b != RIFF_MAGIC[8*idx +: 8]) magic_in[0] = 1'b0;
         if (count_ff >= CW'(8) && count_ff < MINH && b != WAVE_MAGIC[8*idx +: 8])
            magic_in[0] = 1'b0;
         if (count_ff < CW'(3) && b != ID3_MAGIC[8*idx +: 8]) magic_in[1] = 1'b0;
         if (count_ff == CW'(0) && b != SYNC_BYTE) magic_in[2] = 1'b0;
         if (count_ff == CW'(1) && (b & SYNC_MASK) != SYNC_MASK) magic_in[2] = 1'b0;
         if (count_ff >= MINH && !decided_ff) begin
            if (skip_ff != '0) begin
               skip_in = skip_ff - CW'(1);
            end else if (phase_ff < 4'd4) begin
               if (b != FMT_MAGIC[8*phase_ff[1:0] +: 8]) fmt_in = 1'b0;
               phase_in = phase_ff + 4'd1;
            end else if (phase_ff < 4'd8) begin
               len_in[8*phase_ff[1:0] +: 8] = b;
               phase_in = phase_ff + 4'd1;
               if (phase_ff == 4'd7 && !fmt_ff) begin
                  // non-fmt chunk: skip body and pad, clamped to the header window
                  skip_in  = (padded > {{(33-CW){1'b0}}, HB}) ? HB : padded[CW-1:0];
                  phase_in = 4'd0;
                  fmt_in   = 1'b1;
                  len_in   = '0;
               end
            end else if (phase_ff == 4'd8) begin
               fmt_low_in = b;
               phase_in   = 4'd9;
            end else begin
               kind_in    = map_format({b, fmt_low_ff});
               decided_in = 1'b1;
            end
         end
         count_in = count_ff + CW'(1);
      end
   end

   always_comb begin
      if (count_in < MINH) begin
         if (step.ext_hint == HINT_MP3)      code = CODEC_MP3;
         else if (step.ext_hint == HINT_WAV) code = CODEC_PCM;
         else                                code = CODEC_UNKNOWN;
      end else if (magic_in[0]) begin
         code = decided_in ? kind_in : CODEC_PCM;
      end else if (magic_in[1] || magic_in[2]) begin
         code = CODEC_MP3;
      end else begin
         code = (step.ext_hint == HINT_MP3) ? CODEC_MP3 : CODEC_UNKNOWN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (step.valid && step.last)) begin
         count_ff   <= '0;
         magic_ff   <= 3'b111;
         phase_ff   <= 4'd0;
         fmt_ff     <= 1'b1;
         len_ff     <= '0;
         skip_ff    <= '0;
         fmt_low_ff <= '0;
         decided_ff <= 1'b0;
         kind_ff    <= CODEC_PCM;
      end else begin
         count_ff   <= count_in;
         magic_ff   <= magic_in;
         phase_ff   <= phase_in;
         fmt_ff     <= fmt_in;
         len_ff     <= len_in;
         skip_ff    <= skip_in;
         fmt_low_ff <= fmt_low_in;
         decided_ff <= decided_in;
         kind_ff    <= kind_in;
      end
   end

endmodule

// ===== rtl/audio_header_format_sniffer_unit.sv =====
// Header format sniffer: feed the header bytes of a file on the req_ channel,
// one item per byte from offset zero, with req_tlast on the final byte and the
// file extension hint in req_tuser (read with the last byte). One result item
// comes out on the rsp_ channel for each last byte, carrying the codec code;
// other bytes produce nothing.
// Throughput: one item per cycle, except while a last byte waits for the
// result register. Each byte is registered in the input register and processed
// there; its result goes to the result register, which drives rsp_tvalid. The
// per-byte work (magic compares, chunk walk, a 33-bit add and clamp for the
// skip count) fits between the input register and the result register.
// Reset (synchronous, active high) empties both registers and returns the
// walk state to its start; the same start state is restored after every
// last byte. When the receiver stalls, the result holds in its register and
// bytes without a last mark keep flowing; a byte with a last mark waits in
// the input register until the result register frees up, and req_tready
// drops only then.
module audio_header_format_sniffer_unit #(
   parameter int HEADER_BYTES = ahfs_pkg::HEADER_BYTES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       req_tlast,
   input  logic [1:0] req_tuser,   // [1:0] ext_hint
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata    // [2:0] codec_type, [7:3] zero
);
   import ahfs_pkg::*;

   logic       in_vld_ff, in_vld_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   logic [1:0] in_hint_ff;
   logic       out_vld_ff, out_vld_in;
   codec_type  out_code_ff;
   logic       adv;
   step_type   step;
   codec_type  code;

   // a byte without a last mark never needs the result register
   assign adv        = in_vld_ff && (!in_last_ff || !out_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || adv;

   assign step.valid     = adv;
   assign step.data_byte = in_byte_ff;
   assign step.last      = in_last_ff;
   assign step.ext_hint  = in_hint_ff;

   ahfs_core #(.HEADER_BYTES(HEADER_BYTES)) u_core (
      .clock(clock),
      .reset(reset),
      .step (step),
      .code (code)
   );

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_tvalid && req_tready) in_vld_in = 1'b1;
      else if (adv)                 in_vld_in = 1'b0;
      out_vld_in = out_vld_ff;
      if (adv && in_last_ff)  out_vld_in = 1'b1;
      else if (rsp_tready)    out_vld_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
         in_hint_ff <= req_tuser;
      end
      if (adv && in_last_ff) out_code_ff <= code;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {5'd0, out_code_ff};

   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata <= 8'd5))
      else $error("codec code out of range");

   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      (in_vld_ff && in_last_ff && adv) |=> out_vld_ff)
      else $error("last byte processed without a result");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && !rsp_tready) |-> !(adv && in_last_ff))
      else $error("pending result overwritten");

   a_nolast_no_result: assert property (@(posedge clock) disable iff (reset)
      (!out_vld_ff && !(adv && in_last_ff)) |=> !out_vld_ff)
      else $error("result without a last byte");

endmodule

// ===== tb/audio_header_format_sniffer_unit_test.sv =====
module audio_header_format_sniffer_unit_test;
   import ahfs_pkg::*;

   localparam int SNIFF_LIMIT = HEADER_BYTES_DEF;
   localparam int BYTE_TARGET = 1800;
   localparam int CYCLE_LIMIT = 200000;

   typedef struct packed {
      logic [7:0] byte_val;
      logic       is_last;
      hint_type   hint;
      logic       known;
      codec_type  codec;
   } header_row;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;   // [7:0] data_byte
   logic       req_tlast = 1'b0;
   logic [1:0] req_tuser = 2'd0;    // [1:0] ext_hint
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // [2:0] codec_type, [7:3] zero

   int cycle_count = 0;
   int fail_count = 0;
   int results_seen = 0;
   wire calm_window = cycle_count >= 600 && cycle_count < 1400;

   // Predictor state of the header walk
   logic [9:0]  bytes_seen;
   logic [3:0]  magic_live;
   logic [3:0]  walk_pos;
   logic        fmt_tag_live;
   logic [31:0] chunk_size;
   logic [32:0] skip_count;
   logic [7:0]  fmt_low;
   logic        fmt_done;
   codec_type   fmt_codec;

   codec_type  codec_due[$];
   codec_type  due_codec;
   logic [7:0] file_bytes[$];
   header_row  directed_rows[19];

   audio_header_format_sniffer_unit #(
      .HEADER_BYTES(SNIFF_LIMIT)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d codec results outstanding",
                  cycle_count, codec_due.size());
         $display("Verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_tready <= calm_window || ($urandom_range(0, 99) >= 6);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (codec_due.size() == 0) begin
            $error("codec_type: no result due, got %0d", rsp_tdata[2:0]);
            fail_count++;
         end else begin
            due_codec = codec_due.pop_front();
            if (rsp_tdata[2:0] != due_codec) begin
               $error("codec_type: expected %0d, actual %0d", due_codec, rsp_tdata[2:0]);
               fail_count++;
            end
         end
         if (rsp_tdata[7:3] != 5'd0) begin
            $error("rsp_tdata pad: expected 0, actual %0d", rsp_tdata[7:3]);
            fail_count++;
         end
      end
   end

   function automatic void clear_sniff_state();
      bytes_seen = '0;
      magic_live = 4'hF;
      walk_pos = '0;
      fmt_tag_live = 1'b1;
      chunk_size = '0;
      skip_count = '0;
      fmt_low = '0;
      fmt_done = 1'b0;
      fmt_codec = CODEC_PCM;
   endfunction

   // Advance the predictor by one header byte; return 1 when a codec is due.
   function automatic logic sniff_byte(input logic [7:0] b, input logic lst,
                                       input hint_type hint, output codec_type code);
      logic [32:0] pad_skip;
      int i;
      int k;
      i = int'(bytes_seen);
      code = CODEC_UNKNOWN;
      if (i < SNIFF_LIMIT) begin
         if (i < 4 && b != RIFF_MAGIC[8*i +: 8])
            magic_live[0] = 1'b0;
         if (i >= 8 && i < 12 && b != WAVE_MAGIC[8*(i-8) +: 8])
            magic_live[0] = 1'b0;
         if (i < 3 && b != ID3_MAGIC[8*i +: 8])
            magic_live[1] = 1'b0;
         if (i == 0 && b != SYNC_BYTE)
            magic_live[2] = 1'b0;
         if (i == 1 && (b & SYNC_MASK) != SYNC_MASK)
            magic_live[2] = 1'b0;
         if (i >= 12 && !fmt_done) begin
            k = int'(walk_pos);
            if (skip_count != '0) begin
               skip_count = skip_count - 33'd1;
            end else if (k < 4) begin
               if (b != FMT_MAGIC[8*k +: 8])
                  fmt_tag_live = 1'b0;
               walk_pos = walk_pos + 4'd1;
            end else if (k < 8) begin
               chunk_size[8*(k-4) +: 8] = b;
               walk_pos = walk_pos + 4'd1;
               if (k == 7 && !fmt_tag_live) begin
                  // skip body plus pad byte, never past the header window
                  pad_skip = {1'b0, chunk_size} + {32'd0, chunk_size[0]};
                  if (pad_skip > 33'(SNIFF_LIMIT))
                     pad_skip = 33'(SNIFF_LIMIT);
                  skip_count = pad_skip;
                  walk_pos = '0;
                  fmt_tag_live = 1'b1;
                  chunk_size = '0;
               end
            end else if (k == 8) begin
               fmt_low = b;
               walk_pos = 4'd9;
            end else begin
               case ({b, fmt_low})
                  TAG_ALAW:  fmt_codec = CODEC_ALAW;
                  TAG_ULAW:  fmt_codec = CODEC_ULAW;
                  TAG_ADPCM: fmt_codec = CODEC_ADPCM;
                  default:   fmt_codec = CODEC_PCM;
               endcase
               fmt_done = 1'b1;
            end
         end
         bytes_seen = 10'(i + 1);
      end
      if (!lst)
         return 1'b0;
      if (int'(bytes_seen) < MIN_HEADER)
         code = hint == HINT_MP3 ? CODEC_MP3 : (hint == HINT_WAV ? CODEC_PCM : CODEC_UNKNOWN);
      else if (magic_live[0])
         code = fmt_done ? fmt_codec : CODEC_PCM;
      else if (magic_live[2:1] != 2'b00)
         code = CODEC_MP3;
      else
         code = hint == HINT_MP3 ? CODEC_MP3 : CODEC_UNKNOWN;
      clear_sniff_state();
      return 1'b1;
   endfunction

   function automatic void push_word(input logic [31:0] w);
      for (int k = 0; k < 4; k++)
         file_bytes.push_back(w[8*k +: 8]);
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic lst, input hint_type hint,
                            input logic known, input codec_type known_codec);
      codec_type guess;
      logic due;
      if (!calm_window && $urandom_range(0, 99) < 6) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tlast <= lst;
      req_tuser <= hint;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      due = sniff_byte(b, lst, hint, guess);
      if (due)
         codec_due.push_back(known ? known_codec : guess);
   endtask

   initial begin
      int pick;
      int n_chunks;
      int body_len;
      int keep;
      int grow_to;
      int flip_at;
      int file_count;
      int byte_total;
      logic [31:0] chunk_tag;
      logic [31:0] chunk_len;
      logic [15:0] fmt_word;

      file_count = 0;
      byte_total = 0;
      clear_sniff_state();
      // Short files, even a bare ID3 tag: hint decides; a bare RIFF/WAVE header beats the hint
      directed_rows = '{
         '{8'h00, 1'b1, HINT_OTHER, 1'b1, CODEC_UNKNOWN},
         '{8'hFF, 1'b1, HINT_MP3,   1'b1, CODEC_MP3},
         '{8'h80, 1'b1, HINT_WAV,   1'b1, CODEC_PCM},
         '{8'h7F, 1'b1, HINT_SPARE, 1'b1, CODEC_UNKNOWN},
         '{8'h52, 1'b0, HINT_OTHER, 1'b0, CODEC_UNKNOWN},
         '{8'h49, 1'b0, HINT_OTHER, 1'b0, CODEC_UNKNOWN},
         '{8'h46, 1'b0, HINT_OTHER, 1'b0, CODEC_UNKNOWN},
         '{8'h46, 1'b0, HINT_OTHER, 1'b0, CODEC_UNKNOWN},
         '{8'h24, 1'b0, HINT_OTHER, 1'b0, CODEC_UNKNOWN},
         '{8'h00, 1'b0, HINT_OTHER, 1'b0, CODEC_UNKNOWN},
         '{8'h00, 1'b0, HINT_OTHER, 1'b0, CODEC_UNKNOWN},
         '{8'h00, 1'b0, HINT_OTHER, 1'b0, CODEC_UNKNOWN},
         '{8'h57, 1'b0, HINT_OTHER, 1'b0, CODEC_UNKNOWN},
         '{8'h41, 1'b0, HINT_OTHER, 1'b0, CODEC_UNKNOWN},
         '{8'h56, 1'b0, HINT_OTHER, 1'b0, CODEC_UNKNOWN},
         '{8'h45, 1'b1, HINT_MP3,   1'b1, CODEC_PCM},
         '{8'h49, 1'b0, HINT_OTHER, 1'b0, CODEC_UNKNOWN},
         '{8'h44, 1'b0, HINT_OTHER, 1'b0, CODEC_UNKNOWN},
         '{8'h33, 1'b1, HINT_WAV,   1'b1, CODEC_PCM}
      };

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r])
         send_byte(directed_rows[r].byte_val, directed_rows[r].is_last, directed_rows[r].hint,
                   directed_rows[r].known, directed_rows[r].codec);

      while (byte_total < BYTE_TARGET) begin
         file_bytes.delete();
         pick = $urandom_range(0, 99);
         if (pick < 50) begin
            push_word(RIFF_MAGIC);
            push_word($urandom);
            push_word(WAVE_MAGIC);
            n_chunks = $urandom_range(0, 2);
            repeat (n_chunks) begin
               chunk_tag = $urandom;
               // near miss on the fmt tag: only the last byte is random
               if ($urandom_range(0, 3) == 0)
                  chunk_tag = {8'($urandom_range(0, 255)), FMT_MAGIC[23:0]};
               if ($urandom_range(0, 5) == 0)
                  chunk_len = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'($urandom);
               else
                  chunk_len = $urandom_range(0, 21);
               push_word(chunk_tag);
               push_word(chunk_len);
               body_len = chunk_len > 40 ? $urandom_range(0, 40) : chunk_len + chunk_len[0];
               repeat (body_len) file_bytes.push_back(8'($urandom));
            end
            push_word(FMT_MAGIC);
            push_word($urandom_range(14, 40));
            case ($urandom_range(0, 4))
               0: fmt_word = TAG_PCM;
               1: fmt_word = TAG_ALAW;
               2: fmt_word = TAG_ULAW;
               3: fmt_word = TAG_ADPCM;
               default: fmt_word = 16'($urandom);
            endcase
            file_bytes.push_back(fmt_word[7:0]);
            file_bytes.push_back(fmt_word[15:8]);
            repeat ($urandom_range(0, 12)) file_bytes.push_back(8'($urandom));
            // now and then flip a bit in the first 12 header bytes, which may break the magic
            if ($urandom_range(0, 9) == 0) begin
               flip_at = $urandom_range(0, 11);
               file_bytes[flip_at] = file_bytes[flip_at] ^ (8'h01 << $urandom_range(0, 7));
            end
         end else if (pick < 62) begin
            file_bytes.push_back(ID3_MAGIC[7:0]);
            file_bytes.push_back(ID3_MAGIC[15:8]);
            file_bytes.push_back(ID3_MAGIC[23:16]);
            repeat ($urandom_range(0, 30)) file_bytes.push_back(8'($urandom));
         end else if (pick < 74) begin
            file_bytes.push_back(SYNC_BYTE);
            if ($urandom_range(0, 9) == 0)
               file_bytes.push_back(8'($urandom));
            else
               file_bytes.push_back(SYNC_MASK | 8'($urandom_range(0, 31)));
            repeat ($urandom_range(0, 30)) file_bytes.push_back(8'($urandom));
         end else if (pick < 86) begin
            repeat ($urandom_range(1, 40)) file_bytes.push_back(8'($urandom));
         end else begin
            if ($urandom_range(0, 2) == 0)
               push_word(RIFF_MAGIC);
            repeat ($urandom_range(1, 7)) file_bytes.push_back(8'($urandom));
         end

         if ($urandom_range(0, 3) == 0) begin
            keep = $urandom_range(1, file_bytes.size());
            while (file_bytes.size() > keep)
               file_bytes.delete(file_bytes.size() - 1);
         end
         // run past the header window on a few files
         if (file_count == 4 || $urandom_range(0, 199) == 0) begin
            grow_to = SNIFF_LIMIT + $urandom_range(8, 80);
            while (file_bytes.size() < grow_to)
               file_bytes.push_back(8'($urandom));
         end

         foreach (file_bytes[k]) begin
            send_byte(file_bytes[k], k == file_bytes.size() - 1,
                      hint_type'($urandom_range(0, 3)), 1'b0, CODEC_UNKNOWN);
            if (k < SNIFF_LIMIT)
               byte_total++;
         end
         file_count++;
      end

      req_tvalid <= 1'b0;
      while (codec_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Sniffed %0d random files (%0d header bytes) plus the directed headers;",
               file_count, byte_total);
      $display("compared %0d codec results with %0d mismatches.", results_seen, fail_count);
      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
